// File: sv/nsadsr_pkg.sv
// Shared types, constants and helpers of the note sequencer with ADSR envelope.
`default_nettype none
package nsadsr_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int TBL_AW      = $clog2(TABLE_DEPTH);
	localparam int IDX_W       = 8;
	localparam int IDX_XW      = (TBL_AW > IDX_W) ? TBL_AW : IDX_W;

	localparam logic [15:0] END_MARK = 16'h7d64;
	localparam logic [15:0] SILENCE  = 16'h7d00;

	localparam logic [1:0] PH_ATTACK  = 2'd0;
	localparam logic [1:0] PH_DECAY   = 2'd1;
	localparam logic [1:0] PH_RELEASE = 2'd2;

	localparam logic [2:0] REG_DURATION_SCALE   = 3'd0;
	localparam logic [2:0] REG_WIDTH_FIXED_MODE = 3'd1;
	localparam logic [2:0] REG_FIXED_WIDTH      = 3'd2;
	localparam logic [2:0] REG_PEAK_VOLUME      = 3'd3;
	localparam logic [2:0] REG_ATTACK_STEP      = 3'd4;
	localparam logic [2:0] REG_SUSTAIN_VOLUME   = 3'd5;
	localparam logic [2:0] REG_DECAY_STEP       = 3'd6;
	localparam logic [2:0] REG_RELEASE_STEP     = 3'd7;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_LOAD  = 2'd1,
		OP_START = 2'd2,
		OP_STOP  = 2'd3
	} op_t;

	typedef struct packed {
		logic [3:0]  duration_scale;
		logic        width_fixed_mode;
		logic [11:0] fixed_width;
		logic [6:0]  peak_volume;
		logic [6:0]  attack_step;
		logic [6:0]  sustain_volume;
		logic [6:0]  decay_step;
		logic [6:0]  release_step;
	} cfg_t;

	typedef struct packed {
		logic [7:0]  length;
		logic [15:0] pitch;
	} entry_t;

	typedef struct packed {
		logic [15:0] tone_divisor;
		logic [6:0]  volume;
		logic        playing;
		logic [1:0]  envelope_phase;
	} result_t;

	// table pointer advance, modulo the table depth
	function automatic logic [TBL_AW-1:0] ptr_next(input logic [TBL_AW-1:0] p);
		logic [TBL_AW-1:0] r;
		if (p == TBL_AW'(TABLE_DEPTH - 1))
			r = '0;
		else
			r = p + TBL_AW'(1);
		return r;
	endfunction

endpackage
`default_nettype wire

// File: sv/nsadsr_table.sv
// Note table memory: one write port, two registered read ports (entry and the following entry's pitch).
`default_nettype none
module nsadsr_table (
	input  wire logic                       clk,
	input  wire logic                       wr_en,
	input  wire logic [nsadsr_pkg::TBL_AW-1:0] wr_addr,
	input  wire nsadsr_pkg::entry_t         wr_data,
	input  wire logic                       rd_en,
	input  wire logic [nsadsr_pkg::TBL_AW-1:0] rd_addr,
	output nsadsr_pkg::entry_t              rd_entry,
	output logic [15:0]                     rd_next_pitch
);
	import nsadsr_pkg::*;

	entry_t            mem_q [TABLE_DEPTH];
	logic [TBL_AW-1:0] addr_next;

	assign addr_next = ptr_next(rd_addr);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_entry      <= mem_q[rd_addr];
			rd_next_pitch <= mem_q[addr_next].pitch;
		end
	end

endmodule
`default_nettype wire

// File: sv/nsadsr_core.sv
// Player state registers, note fetch and envelope update for one item.
`default_nettype none
module nsadsr_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          fire,
	input  wire nsadsr_pkg::op_t               op,
	input  wire nsadsr_pkg::cfg_t              cfg,
	input  wire nsadsr_pkg::entry_t            entry,
	input  wire logic [15:0]                   next_pitch,
	output logic [nsadsr_pkg::TBL_AW-1:0]      ptr,
	output nsadsr_pkg::result_t                result
);
	import nsadsr_pkg::*;

	logic [TBL_AW-1:0] ptr_q,   ptr_n;
	logic [11:0]       left_q,  left_n;
	logic [11:0]       tin_q,   tin_n;
	logic [11:0]       width_q, width_n;
	logic [15:0]       pitch_q, pitch_n;
	logic [6:0]        vol_q,   vol_n;
	logic [1:0]        phase_q, phase_n;
	logic              play_q,  play_n;

	logic [11:0] dur;
	logic [11:0] scale_x;
	logic [7:0]  sum_a;

	assign ptr     = ptr_q;
	assign scale_x = 12'(cfg.duration_scale);
	assign dur     = 12'(entry.length) * scale_x;

	always_comb begin
		ptr_n   = ptr_q;
		left_n  = left_q;
		tin_n   = tin_q;
		width_n = width_q;
		pitch_n = pitch_q;
		vol_n   = vol_q;
		phase_n = phase_q;
		play_n  = play_q;
		sum_a   = {1'b0, vol_q} + {1'b0, cfg.attack_step};
		unique case (op)
			OP_TICK: begin
				if (play_q) begin
					if (left_q != 12'd0) begin
						left_n = left_q - 12'd1;
					end else begin
						// note spent: fetch next entry, rewind at end marker
						phase_n = PH_ATTACK;
						tin_n   = 12'd0;
						left_n  = dur;
						if (cfg.width_fixed_mode)
							width_n = cfg.fixed_width;
						else if (dur >= scale_x)
							width_n = dur - scale_x;
						else
							width_n = 12'd0;
						pitch_n = entry.pitch;
						ptr_n   = (next_pitch == END_MARK) ? '0 : ptr_next(ptr_q);
					end
					if (tin_n != 12'hfff)
						tin_n = tin_n + 12'd1;
					if (tin_n >= width_n)
						phase_n = PH_RELEASE;
					priority case (phase_n)
						PH_ATTACK: begin
							if (sum_a >= {1'b0, cfg.peak_volume}) begin
								phase_n = PH_DECAY;
								vol_n   = cfg.peak_volume;
							end else begin
								vol_n = sum_a[6:0];
							end
						end
						PH_DECAY: begin
							if ({1'b0, vol_q} <= {1'b0, cfg.sustain_volume} + {1'b0, cfg.decay_step})
								vol_n = cfg.sustain_volume;
							else
								vol_n = vol_q - cfg.decay_step;
						end
						default: begin
							if ({1'b0, vol_q} <= 8'd1 + {1'b0, cfg.release_step})
								vol_n = 7'd1;
							else
								vol_n = vol_q - cfg.release_step;
						end
					endcase
				end
			end
			OP_LOAD: begin
			end
			OP_START: begin
				ptr_n  = '0;
				left_n = 12'd0;
				play_n = 1'b1;
			end
			OP_STOP: begin
				ptr_n  = '0;
				play_n = 1'b0;
			end
		endcase
	end

	always_comb begin
		result.tone_divisor   = (!play_n || vol_n == 7'd1) ? SILENCE : pitch_n;
		result.volume         = vol_n;
		result.playing        = play_n;
		result.envelope_phase = phase_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q   <= '0;
			left_q  <= 12'd0;
			tin_q   <= 12'd0;
			width_q <= 12'd0;
			pitch_q <= 16'd0;
			vol_q   <= 7'd8;
			phase_q <= PH_ATTACK;
			play_q  <= 1'b0;
		end else if (fire) begin
			ptr_q   <= ptr_n;
			left_q  <= left_n;
			tin_q   <= tin_n;
			width_q <= width_n;
			pitch_q <= pitch_n;
			vol_q   <= vol_n;
			phase_q <= phase_n;
			play_q  <= play_n;
		end
	end

endmodule
`default_nettype wire

// File: sv/note_sequencer_adsr_envelope.sv
// Top level: tick-driven tune player with note table and ADSR envelope.
//
//  channel | signals                                            | dir | role
//  --------+----------------------------------------------------+-----+--------------------------
//  in      | in_valid/in_ready, opcode, entry_index,            | in  | tick, load, start, stop
//          | entry_pitch, entry_length                          |     |
//  out     | out_valid/out_ready, tone_divisor, volume,         | out | one result per item
//          | playing, envelope_phase                            |     |
//  cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data           | in  | register writes, always ready
//
// Order: a load writes the table at its transfer; the next item may enter as the load
// leaves stage 1. A tick reads the entry at the pointer and the pitch of the one after it
// at its transfer. Tick, start and stop update the state, pointer included, as they leave
// stage 1; the input waits for that. A result is registered as its item leaves stage 1.
// Reset: pointer, counters, flags and registers to defaults; table not cleared.
// A stalled output holds its result; one more item waits in stage 1 behind it.
`default_nettype none
module note_sequencer_adsr_envelope (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  opcode,
	input  wire logic [7:0]  entry_index,
	input  wire logic [15:0] entry_pitch,
	input  wire logic [7:0]  entry_length,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [15:0]      tone_divisor,
	output logic [6:0]       volume,
	output logic             playing,
	output logic [1:0]       envelope_phase,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [11:0] cfg_data
);
	import nsadsr_pkg::*;

	cfg_t              cfg_q;
	logic              valid_s1;
	op_t               op_s1;
	logic              out_valid_q;
	result_t           out_q;
	result_t           result;

	logic              in_xfer;
	logic              fire;
	logic [IDX_XW-1:0] idx_x;
	logic              wr_en;
	logic              rd_en;
	entry_t            wr_data;
	entry_t            rd_entry;
	logic [15:0]       rd_next_pitch;
	logic [TBL_AW-1:0] ptr;

	// config registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.duration_scale   <= 4'd3;
			cfg_q.width_fixed_mode <= 1'b0;
			cfg_q.fixed_width      <= 12'd12;
			cfg_q.peak_volume      <= 7'd50;
			cfg_q.attack_step      <= 7'd20;
			cfg_q.sustain_volume   <= 7'd20;
			cfg_q.decay_step       <= 7'd10;
			cfg_q.release_step     <= 7'd4;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_DURATION_SCALE:   cfg_q.duration_scale   <= cfg_data[3:0];
				REG_WIDTH_FIXED_MODE: cfg_q.width_fixed_mode <= cfg_data[0];
				REG_FIXED_WIDTH:      cfg_q.fixed_width      <= cfg_data;
				REG_PEAK_VOLUME:      cfg_q.peak_volume      <= cfg_data[6:0];
				REG_ATTACK_STEP:      cfg_q.attack_step      <= cfg_data[6:0];
				REG_SUSTAIN_VOLUME:   cfg_q.sustain_volume   <= cfg_data[6:0];
				REG_DECAY_STEP:       cfg_q.decay_step       <= cfg_data[6:0];
				REG_RELEASE_STEP:     cfg_q.release_step     <= cfg_data[6:0];
			endcase
		end
	end

	// stage 1 completes when the output register is free or being drained
	assign fire = valid_s1 && (!out_valid_q || out_ready);

	// stage 1 holding an item blocks the next item, unless it holds a load that completes
	assign in_ready = !valid_s1 || (fire && op_s1 == OP_LOAD);
	assign in_xfer  = in_valid && in_ready;

	// table access at transfer time
	assign idx_x        = IDX_XW'(entry_index);
	assign wr_en        = in_xfer && opcode == OP_LOAD
	                      && {1'b0, idx_x} < (IDX_XW + 1)'(TABLE_DEPTH);
	assign rd_en        = in_xfer && opcode == OP_TICK;
	assign wr_data      = '{length: entry_length, pitch: entry_pitch};

	nsadsr_table u_table (
		.clk           (clk),
		.wr_en         (wr_en),
		.wr_addr       (idx_x[TBL_AW-1:0]),
		.wr_data       (wr_data),
		.rd_en         (rd_en),
		.rd_addr       (ptr),
		.rd_entry      (rd_entry),
		.rd_next_pitch (rd_next_pitch)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			op_s1    <= OP_TICK;
		end else begin
			if (in_xfer) begin
				valid_s1 <= 1'b1;
				op_s1    <= op_t'(opcode);
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	nsadsr_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.op         (op_s1),
		.cfg        (cfg_q),
		.entry      (rd_entry),
		.next_pitch (rd_next_pitch),
		.ptr        (ptr),
		.result     (result)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q <= result;
		end
	end

	assign out_valid      = out_valid_q;
	assign tone_divisor   = out_q.tone_divisor;
	assign volume         = out_q.volume;
	assign playing        = out_q.playing;
	assign envelope_phase = out_q.envelope_phase;

endmodule
`default_nettype wire
